FILE: design/swq_pkg.sv
// shared types and codes for the semaphore wait queue table
package swq_pkg;

  localparam int KEY_W = 32;
  localparam int PID_W = 5;
  localparam int REQ_W = 2;
  localparam int ST_W  = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_OUT    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;

  // field write enables of the descriptor memory
  typedef struct packed {
    logic key;
    logic head;
    logic tail;
  } desc_wen_t;

  // field write enables of the process link memory
  typedef struct packed {
    logic nxt;
    logic prv;
    logic dsc;
  } proc_wen_t;

endpackage

FILE: design/semaphore_wait_queue_table.sv
// top level: semaphore wait queue table with its request sequencer
//
// Requests arrive on the in channel (in_valid/in_ready) as one word of
// req_type, sem_key and proc_id; each gives exactly one result word on the
// out channel (out_valid/out_ready) carrying status and proc_out.
// Insert, pop and peek search the descriptor memory for the key, one entry
// per cycle, and the scan stops at the matching descriptor; a missing key
// is compared against every descriptor. Pop of a longer queue then reads
// the head's link and writes the new head, insert on an existing key links
// the process behind the tail, and insert on a missing key takes a free
// descriptor. Removal of a given process follows its doubly linked entry
// and skips the second link fix when it is alone in its queue; requests
// rejected up front go straight to the result.
// One request is in work at a time: in_ready is high only while the
// sequencer is idle, which it enters as the result is registered. The result
// sits in an output register; a stalled receiver holds the sequencer in its
// final state until the register frees.
// Reset (rst, synchronous) frees every descriptor and unblocks every
// process at once through flip-flop valid bits; no clearing pass is needed.
module semaphore_wait_queue_table #(
  parameter int NUM_PROCS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [swq_pkg::REQ_W-1:0] req_type,
  input  logic [swq_pkg::KEY_W-1:0] sem_key,
  input  logic [swq_pkg::PID_W-1:0] proc_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [swq_pkg::ST_W-1:0]  status,
  output logic [swq_pkg::PID_W-1:0] proc_out
);

  localparam int AW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int CW = $clog2(NUM_PROCS + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_PROCS - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(NUM_PROCS);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_INS_LINK = 4'd2;
  localparam logic [3:0] S_INS_SELF = 4'd3;
  localparam logic [3:0] S_POP_RD   = 4'd4;
  localparam logic [3:0] S_POP_WB   = 4'd5;
  localparam logic [3:0] S_OUT_RD   = 4'd6;
  localparam logic [3:0] S_OUT_DESC = 4'd7;
  localparam logic [3:0] S_OUT_FIX1 = 4'd8;
  localparam logic [3:0] S_OUT_FIX2 = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]                state;
  logic [NUM_PROCS-1:0]      in_use;
  logic [NUM_PROCS-1:0]      blocked;
  logic [swq_pkg::REQ_W-1:0] req;
  logic [swq_pkg::KEY_W-1:0] key;
  logic [swq_pkg::PID_W-1:0] pid;
  logic [CW-1:0]             cnt;
  logic                      cmp_vld;
  logic [AW-1:0]             cmp_idx;
  logic                      free_found;
  logic [AW-1:0]             free_idx;
  logic [AW-1:0]             dsel;
  logic [swq_pkg::PID_W-1:0] hd;
  logic [swq_pkg::PID_W-1:0] tl;
  logic [swq_pkg::PID_W-1:0] nx;
  logic [swq_pkg::PID_W-1:0] pv;
  logic                      is_tail;
  logic [swq_pkg::ST_W-1:0]  res_status;
  logic [swq_pkg::PID_W-1:0] res_pid;

  // memory ports
  logic [AW-1:0]             desc_wr_addr;
  swq_pkg::desc_wen_t        desc_wen;
  logic [swq_pkg::PID_W-1:0] desc_wr_head;
  logic [swq_pkg::PID_W-1:0] desc_wr_tail;
  logic [AW-1:0]             desc_rd_addr;
  logic [swq_pkg::KEY_W-1:0] desc_rd_key;
  logic [swq_pkg::PID_W-1:0] desc_rd_head;
  logic [swq_pkg::PID_W-1:0] desc_rd_tail;
  logic [AW-1:0]             proc_wr_addr;
  swq_pkg::proc_wen_t        proc_wen;
  logic [swq_pkg::PID_W-1:0] proc_wr_nxt;
  logic [swq_pkg::PID_W-1:0] proc_wr_prv;
  logic [AW-1:0]             proc_wr_dsc;
  logic [AW-1:0]             proc_rd_addr;
  logic [swq_pkg::PID_W-1:0] proc_rd_nxt;
  logic [swq_pkg::PID_W-1:0] proc_rd_prv;
  logic [AW-1:0]             proc_rd_dsc;

  // scan compare stage and request checks
  logic          in_pid_ok;
  logic [AW-1:0] in_pidx;
  logic          hit;
  logic          last;
  logic          scan_end;
  logic          new_free_found;
  logic [AW-1:0] new_free_idx;
  logic          ih;
  logic          it;
  logic          accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign in_pid_ok = (32'(proc_id) < 32'(NUM_PROCS));
  assign in_pidx   = AW'(proc_id);

  assign hit      = cmp_vld && in_use[cmp_idx] && (desc_rd_key == key);
  assign last     = (cmp_idx == LAST_IDX);
  assign scan_end = cmp_vld && (hit || last);
  assign new_free_found = free_found || !in_use[cmp_idx];
  assign new_free_idx   = free_found ? free_idx : cmp_idx;

  assign ih = (desc_rd_head == pid);
  assign it = (desc_rd_tail == pid);

  swq_desc_mem #(.DEPTH(NUM_PROCS), .AW(AW)) u_desc_mem (
    .clk     (clk),
    .wr_addr (desc_wr_addr),
    .wen     (desc_wen),
    .wr_key  (key),
    .wr_head (desc_wr_head),
    .wr_tail (desc_wr_tail),
    .rd_addr (desc_rd_addr),
    .rd_key  (desc_rd_key),
    .rd_head (desc_rd_head),
    .rd_tail (desc_rd_tail)
  );

  swq_proc_mem #(.DEPTH(NUM_PROCS), .AW(AW)) u_proc_mem (
    .clk     (clk),
    .wr_addr (proc_wr_addr),
    .wen     (proc_wen),
    .wr_nxt  (proc_wr_nxt),
    .wr_prv  (proc_wr_prv),
    .wr_dsc  (proc_wr_dsc),
    .rd_addr (proc_rd_addr),
    .rd_nxt  (proc_rd_nxt),
    .rd_prv  (proc_rd_prv),
    .rd_dsc  (proc_rd_dsc)
  );

  // read address selection
  assign desc_rd_addr = (state == S_OUT_DESC) ? proc_rd_dsc : cnt[AW-1:0];
  assign proc_rd_addr = (state == S_POP_RD) ? AW'(hd) : AW'(pid);

  // descriptor memory writes
  always_comb begin
    desc_wr_addr = dsel;
    desc_wen     = '0;
    desc_wr_head = pid;
    desc_wr_tail = pid;
    case (state)
      S_SCAN: begin
        if (req == swq_pkg::REQ_INSERT && hit) begin
          desc_wr_addr  = cmp_idx;
          desc_wen.tail = 1'b1;
        end else if (req == swq_pkg::REQ_INSERT && scan_end && new_free_found) begin
          desc_wr_addr = new_free_idx;
          desc_wen     = '{key: 1'b1, head: 1'b1, tail: 1'b1};
        end
      end
      S_POP_WB: begin
        desc_wen.head = 1'b1;
        desc_wr_head  = proc_rd_nxt;
      end
      S_OUT_FIX1: begin
        if (!(ih && it)) begin
          desc_wen.head = ih;
          desc_wen.tail = it;
          desc_wr_head  = nx;
          desc_wr_tail  = pv;
        end
      end
      default: begin
      end
    endcase
  end

  // process link memory writes
  always_comb begin
    proc_wr_addr = AW'(pid);
    proc_wen     = '0;
    proc_wr_nxt  = pid;
    proc_wr_prv  = tl;
    proc_wr_dsc  = dsel;
    case (state)
      S_INS_LINK: begin
        proc_wr_addr = AW'(tl);
        proc_wen.nxt = 1'b1;
      end
      S_INS_SELF: begin
        proc_wen.prv = 1'b1;
        proc_wen.dsc = 1'b1;
      end
      S_OUT_FIX1: begin
        if (!ih) begin
          proc_wr_addr = AW'(pv);
          proc_wen.nxt = 1'b1;
          proc_wr_nxt  = nx;
        end
      end
      S_OUT_FIX2: begin
        if (!is_tail) begin
          proc_wr_addr = AW'(nx);
          proc_wen.prv = 1'b1;
          proc_wr_prv  = pv;
        end
      end
      default: begin
      end
    endcase
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_use  <= '0;
      blocked <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= (state == S_SCAN) && (cnt < CNT_END) && !scan_end;
      case (state)
        S_IDLE: begin
          if (accept) begin
            req        <= req_type;
            key        <= sem_key;
            pid        <= proc_id;
            cnt        <= '0;
            free_found <= 1'b0;
            res_pid    <= '0;
            res_status <= swq_pkg::ST_OK;
            if (req_type == swq_pkg::REQ_INSERT && (!in_pid_ok || blocked[in_pidx])) begin
              res_status <= swq_pkg::ST_ABSENT;
              state      <= S_DONE;
            end else if (req_type == swq_pkg::REQ_OUT) begin
              if (!in_pid_ok || !blocked[in_pidx]) begin
                res_status <= swq_pkg::ST_ABSENT;
                state      <= S_DONE;
              end else begin
                state <= S_OUT_RD;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cnt     <= cnt + 1'b1;
          cmp_idx <= cnt[AW-1:0];
          if (cmp_vld && !hit && !in_use[cmp_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= cmp_idx;
          end
          if (hit) begin
            dsel <= cmp_idx;
            hd   <= desc_rd_head;
            tl   <= desc_rd_tail;
            case (req)
              swq_pkg::REQ_INSERT: begin
                state <= S_INS_LINK;
              end
              swq_pkg::REQ_POP: begin
                res_pid                    <= desc_rd_head;
                blocked[AW'(desc_rd_head)] <= 1'b0;
                if (desc_rd_tail == desc_rd_head) begin
                  in_use[cmp_idx] <= 1'b0;
                  state           <= S_DONE;
                end else begin
                  state <= S_POP_RD;
                end
              end
              default: begin
                res_pid <= desc_rd_head;
                state   <= S_DONE;
              end
            endcase
          end else if (scan_end) begin
            if (req != swq_pkg::REQ_INSERT) begin
              res_status <= swq_pkg::ST_ABSENT;
              state      <= S_DONE;
            end else if (new_free_found) begin
              dsel                 <= new_free_idx;
              tl                   <= pid;
              in_use[new_free_idx] <= 1'b1;
              state                <= S_INS_SELF;
            end else begin
              res_status <= swq_pkg::ST_FULL;
              state      <= S_DONE;
            end
          end
        end
        S_INS_LINK: begin
          state <= S_INS_SELF;
        end
        S_INS_SELF: begin
          blocked[AW'(pid)] <= 1'b1;
          state             <= S_DONE;
        end
        S_POP_RD: begin
          state <= S_POP_WB;
        end
        S_POP_WB: begin
          state <= S_DONE;
        end
        S_OUT_RD: begin
          state <= S_OUT_DESC;
        end
        S_OUT_DESC: begin
          nx    <= proc_rd_nxt;
          pv    <= proc_rd_prv;
          dsel  <= proc_rd_dsc;
          state <= S_OUT_FIX1;
        end
        S_OUT_FIX1: begin
          blocked[AW'(pid)] <= 1'b0;
          res_pid           <= pid;
          is_tail           <= it;
          if (ih && it) begin
            in_use[dsel] <= 1'b0;
            state        <= S_DONE;
          end else begin
            state <= S_OUT_FIX2;
          end
        end
        S_OUT_FIX2: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
      status    <= res_status;
      proc_out  <= res_pid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  // an accepted word always starts the sequencer
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer stayed idle after accepting a word");

  // the scan compare stage is live only while scanning
  a_cmp_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> (state == S_SCAN))
    else $error("scan compare valid outside scan");

  // results carry only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == swq_pkg::ST_OK || status == swq_pkg::ST_FULL ||
                   status == swq_pkg::ST_ABSENT))
    else $error("undefined status code");

  // a failed request reports process zero
  a_fail_pid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != swq_pkg::ST_OK) |-> (proc_out == '0))
    else $error("nonzero process on failed request");
`endif

endmodule

FILE: design/swq_desc_mem.sv
// descriptor memory: key, queue head and queue tail per descriptor
module swq_desc_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                     clk,
  input  logic [AW-1:0]            wr_addr,
  input  swq_pkg::desc_wen_t       wen,
  input  logic [swq_pkg::KEY_W-1:0] wr_key,
  input  logic [swq_pkg::PID_W-1:0] wr_head,
  input  logic [swq_pkg::PID_W-1:0] wr_tail,
  input  logic [AW-1:0]            rd_addr,
  output logic [swq_pkg::KEY_W-1:0] rd_key,
  output logic [swq_pkg::PID_W-1:0] rd_head,
  output logic [swq_pkg::PID_W-1:0] rd_tail
);

  logic [swq_pkg::KEY_W-1:0] key_mem  [DEPTH];
  logic [swq_pkg::PID_W-1:0] head_mem [DEPTH];
  logic [swq_pkg::PID_W-1:0] tail_mem [DEPTH];

  // one write port with field enables, one registered read port
  always_ff @(posedge clk) begin
    if (wen.key) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wen.head) begin
      head_mem[wr_addr] <= wr_head;
    end
    if (wen.tail) begin
      tail_mem[wr_addr] <= wr_tail;
    end
    rd_key  <= key_mem[rd_addr];
    rd_head <= head_mem[rd_addr];
    rd_tail <= tail_mem[rd_addr];
  end

endmodule

FILE: design/swq_proc_mem.sv
// process link memory: next and previous in queue, owning descriptor
module swq_proc_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic [AW-1:0]             wr_addr,
  input  swq_pkg::proc_wen_t        wen,
  input  logic [swq_pkg::PID_W-1:0] wr_nxt,
  input  logic [swq_pkg::PID_W-1:0] wr_prv,
  input  logic [AW-1:0]             wr_dsc,
  input  logic [AW-1:0]             rd_addr,
  output logic [swq_pkg::PID_W-1:0] rd_nxt,
  output logic [swq_pkg::PID_W-1:0] rd_prv,
  output logic [AW-1:0]             rd_dsc
);

  logic [swq_pkg::PID_W-1:0] nxt_mem [DEPTH];
  logic [swq_pkg::PID_W-1:0] prv_mem [DEPTH];
  logic [AW-1:0]             dsc_mem [DEPTH];

  // one write port with field enables, one registered read port
  always_ff @(posedge clk) begin
    if (wen.nxt) begin
      nxt_mem[wr_addr] <= wr_nxt;
    end
    if (wen.prv) begin
      prv_mem[wr_addr] <= wr_prv;
    end
    if (wen.dsc) begin
      dsc_mem[wr_addr] <= wr_dsc;
    end
    rd_nxt <= nxt_mem[rd_addr];
    rd_prv <= prv_mem[rd_addr];
    rd_dsc <= dsc_mem[rd_addr];
  end

endmodule
